// ===== design/parallel_code_qualifier_history_top_defines.svh =====
`ifndef PARALLEL_CODE_QUALIFIER_HISTORY_TOP_DEFINES_SVH
`define PARALLEL_CODE_QUALIFIER_HISTORY_TOP_DEFINES_SVH

// Same-cycle check: when ante holds at a clock edge, cons must hold at that edge.
`define PCQ_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle check: when ante holds at a clock edge, cons must hold at the edge after it.
`define PCQ_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/pcq_pkg.sv =====
`default_nettype none

package pcq_pkg;

	localparam int CODE_W    = 4;
	localparam int STATE_W   = 5;
	localparam int SLOT_W    = 5;
	localparam int TIME_W    = 32;
	localparam int HOLDOFF_W = 16;
	localparam int REPEAT_W  = 8;
	localparam int PATTERN_W = 20;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = PATTERN_W;

	localparam int HISTORY_DEPTH_DEF = 4;

	localparam logic [STATE_W-1:0] NONE_CODE = STATE_W'(16);

	localparam logic [HOLDOFF_W-1:0] HOLDOFF_RST = HOLDOFF_W'(50);
	localparam logic [REPEAT_W-1:0]  REPEAT_RST  = REPEAT_W'(50);
	localparam logic [PATTERN_W-1:0] PATTERN_RST = PATTERN_W'(541200);

	localparam logic [CFG_IDX_W-1:0] REG_HOLDOFF = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_REPEATS = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN = CFG_IDX_W'(2);

	typedef struct packed {
		logic [HOLDOFF_W-1:0] holdoff_ms;
		logic [REPEAT_W-1:0]  required_repeats;
		logic [PATTERN_W-1:0] match_pattern;
	} cfg_t;

	typedef struct packed {
		logic [STATE_W-1:0] current_state;
		logic [STATE_W-1:0] previous_state;
		logic               changed;
		logic [TIME_W-1:0]  elapsed_ms;
		logic               sequence_match;
	} res_t;

endpackage

`default_nettype wire

// ===== design/pcq_cfg.sv =====
`default_nettype none

module pcq_cfg (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            wr_en,
	input  wire logic [pcq_pkg::CFG_IDX_W-1:0]   wr_index,
	input  wire logic [pcq_pkg::CFG_DATA_W-1:0]  wr_data,
	output pcq_pkg::cfg_t                        cfg
);

	pcq_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.holdoff_ms       <= pcq_pkg::HOLDOFF_RST;
			cfg_q.required_repeats <= pcq_pkg::REPEAT_RST;
			cfg_q.match_pattern    <= pcq_pkg::PATTERN_RST;
		end else if (wr_en) begin
			// Indexes past the last register are dropped.
			unique case (wr_index)
				pcq_pkg::REG_HOLDOFF: begin
					cfg_q.holdoff_ms <= wr_data[pcq_pkg::HOLDOFF_W-1:0];
				end
				pcq_pkg::REG_REPEATS: begin
					cfg_q.required_repeats <= wr_data[pcq_pkg::REPEAT_W-1:0];
				end
				pcq_pkg::REG_PATTERN: begin
					cfg_q.match_pattern <= wr_data[pcq_pkg::PATTERN_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// ===== design/pcq_core.sv =====
`default_nettype none

module pcq_core #(
	parameter int HISTORY_DEPTH = pcq_pkg::HISTORY_DEPTH_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         fire,
	input  wire logic [pcq_pkg::CODE_W-1:0]   code,
	input  wire logic [pcq_pkg::TIME_W-1:0]   now_ms,
	input  pcq_pkg::cfg_t                     cfg,
	output pcq_pkg::res_t                     res
);

	localparam int HIST_W = pcq_pkg::SLOT_W * HISTORY_DEPTH;
	localparam int CMP_W  = (HIST_W > pcq_pkg::PATTERN_W) ? HIST_W : pcq_pkg::PATTERN_W;

	logic [pcq_pkg::STATE_W-1:0]  accepted_q;
	logic [pcq_pkg::STATE_W-1:0]  prior_q;
	logic [pcq_pkg::STATE_W-1:0]  last_seen_q;
	logic [pcq_pkg::REPEAT_W-1:0] repeat_q;
	logic [pcq_pkg::TIME_W-1:0]   change_time_q;
	logic [pcq_pkg::SLOT_W-1:0]   history_q [HISTORY_DEPTH];

	logic [pcq_pkg::STATE_W-1:0] code_ext;
	logic [pcq_pkg::TIME_W-1:0]  elapsed_old;
	logic                        holdoff_hit;
	logic                        same_code;
	logic                        below_count;
	logic                        change;
	logic [HIST_W-1:0]           hist_new;
	logic                        pattern_hit;

	assign code_ext    = pcq_pkg::STATE_W'(code);
	assign elapsed_old = now_ms - change_time_q;
	assign holdoff_hit = (elapsed_old <= pcq_pkg::TIME_W'(cfg.holdoff_ms))
		&& (accepted_q != pcq_pkg::NONE_CODE);
	assign same_code   = (code_ext == last_seen_q);
	assign below_count = (repeat_q < cfg.required_repeats);
	// Outside holdoff, a new code is taken once its run reached the threshold and recurs.
	assign change      = !holdoff_hit && same_code && !below_count && (code_ext != accepted_q);

	// History as it stands after a change, newest slot in the low bits.
	always_comb begin
		hist_new[pcq_pkg::SLOT_W-1:0] = code_ext;
		for (int i = 1; i < HISTORY_DEPTH; i++) begin
			hist_new[i*pcq_pkg::SLOT_W +: pcq_pkg::SLOT_W] = history_q[i-1];
		end
	end

	assign pattern_hit = (CMP_W'(hist_new) == CMP_W'(cfg.match_pattern));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accepted_q    <= pcq_pkg::NONE_CODE;
			prior_q       <= pcq_pkg::NONE_CODE;
			last_seen_q   <= pcq_pkg::NONE_CODE;
			repeat_q      <= '0;
			change_time_q <= '0;
			for (int i = 0; i < HISTORY_DEPTH; i++) begin
				history_q[i] <= pcq_pkg::NONE_CODE;
			end
		end else if (fire) begin
			if (!holdoff_hit) begin
				if (!same_code) begin
					repeat_q    <= pcq_pkg::REPEAT_W'(1);
					last_seen_q <= code_ext;
				end else if (below_count) begin
					repeat_q <= repeat_q + pcq_pkg::REPEAT_W'(1);
				end
			end
			if (change) begin
				change_time_q <= now_ms;
				prior_q       <= accepted_q;
				accepted_q    <= code_ext;
				for (int i = 1; i < HISTORY_DEPTH; i++) begin
					history_q[i] <= history_q[i-1];
				end
				history_q[0] <= code_ext;
			end
		end
	end

	always_comb begin
		res.current_state  = change ? code_ext : accepted_q;
		res.previous_state = change ? accepted_q : prior_q;
		res.changed        = change;
		res.elapsed_ms     = change ? '0 : elapsed_old;
		res.sequence_match = change && pattern_hit;
	end

endmodule

`default_nettype wire

// ===== design/parallel_code_qualifier_history_top.sv =====
// Channel | Direction | Handshake            | Payload
// in      | input     | in_valid / in_stall   | code, now_ms
// out     | output    | out_valid / out_stall | current_state, previous_state, changed,
//         |           |                       | elapsed_ms, sequence_match
// cfg     | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One poll per cycle is sustained while out_stall is low; a poll passes through the input
// register, then the result register, before its result is valid on the out channel.
// The debounce state updates when an item moves from the input to the result register.
// The configuration port is always ready. Reset is asynchronous and restores the
// register defaults and the "nothing accepted" state.
// While out_stall holds, the input register still fills once before in_stall rises.
`default_nettype none
`include "parallel_code_qualifier_history_top_defines.svh"

module parallel_code_qualifier_history_top #(
	parameter int HISTORY_DEPTH = pcq_pkg::HISTORY_DEPTH_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,

	input  wire logic                             in_valid,
	output logic                                  in_stall,
	input  wire logic [pcq_pkg::CODE_W-1:0]       code,
	input  wire logic [pcq_pkg::TIME_W-1:0]       now_ms,

	output logic                                  out_valid,
	input  wire logic                             out_stall,
	output logic [pcq_pkg::STATE_W-1:0]           current_state,
	output logic [pcq_pkg::STATE_W-1:0]           previous_state,
	output logic                                  changed,
	output logic [pcq_pkg::TIME_W-1:0]            elapsed_ms,
	output logic                                  sequence_match,

	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [pcq_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [pcq_pkg::CFG_DATA_W-1:0]   cfg_data
);

	logic                          valid_s1;
	logic [pcq_pkg::CODE_W-1:0]    code_s1;
	logic [pcq_pkg::TIME_W-1:0]    now_s1;
	logic                          valid_s2;
	pcq_pkg::res_t                 res_s2;

	logic                          adv;
	logic                          fire;
	logic                          in_take;
	pcq_pkg::cfg_t                 cfg;
	pcq_pkg::res_t                 res_next;

	// The result register can load when it is empty or its transfer completes now.
	assign adv      = !valid_s2 || !out_stall;
	assign fire     = valid_s1 && adv;
	assign in_stall = valid_s1 && !adv;
	assign in_take  = in_valid && !in_stall;
	assign cfg_ready = 1'b1;

	pcq_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	pcq_core #(
		.HISTORY_DEPTH (HISTORY_DEPTH)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.code   (code_s1),
		.now_ms (now_s1),
		.cfg    (cfg),
		.res    (res_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!valid_s1 || adv) begin
			valid_s1 <= in_take;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			code_s1 <= code;
			now_s1  <= now_ms;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_s2 <= res_next;
		end
	end

	assign out_valid      = valid_s2;
	assign current_state  = res_s2.current_state;
	assign previous_state = res_s2.previous_state;
	assign changed        = res_s2.changed;
	assign elapsed_ms     = res_s2.elapsed_ms;
	assign sequence_match = res_s2.sequence_match;

	`PCQ_ASSERT_NOW(a_match_needs_change, out_valid && sequence_match, changed, "match without change")
	`PCQ_ASSERT_NOW(a_change_resets_time, out_valid && changed, (elapsed_ms == '0) && (current_state != previous_state), "bad change result")
	`PCQ_ASSERT_NOW(a_stall_only_when_full, in_stall, valid_s1 && valid_s2, "input stalled with room")
	`PCQ_ASSERT_NEXT(a_s1_moves_to_s2, fire, valid_s2, "stage 1 item lost")

endmodule

`default_nettype wire
